FILE: hdl/altbit_pkg.sv
package altbit_pkg;

  // payload geometry
  localparam int PayloadBytes = 20;
  localparam int PayloadBits  = 160;
  localparam int CsumWidth    = 13;
  localparam int TimerWidth   = 16;
  localparam logic [TimerWidth-1:0] TimeoutReset = 16'd15;

  // event codes on the input channel
  typedef enum logic [1:0] {
    CmdMessage = 2'd0,
    CmdPacket  = 2'd1,
    CmdTimer   = 2'd2
  } cmd_e;

  // result status codes
  typedef enum logic [2:0] {
    StSent       = 3'd0,
    StBusy       = 3'd1,
    StCorruptAck = 3'd2,
    StWrongAck   = 3'd3,
    StAckOk      = 3'd4,
    StResent     = 3'd5,
    StTimerIgn   = 3'd6
  } status_e;

  // sum of the counted payload bytes, each byte signed, as a balanced adder tree
  function automatic logic signed [CsumWidth-1:0] byte_sum(input logic [PayloadBits-1:0] data);
    logic signed [CsumWidth-1:0] part [PayloadBytes];
    for (int i = 0; i < PayloadBytes; i++) begin
      part[i] = CsumWidth'(signed'(data[8*i +: 8]));
    end
    // pairwise reduction, an odd leftover moves up unchanged
    for (int n = PayloadBytes; n > 1; n = (n + 1) / 2) begin
      for (int j = 0; j < n / 2; j++) begin
        part[j] = part[2*j] + part[2*j+1];
      end
      if (n % 2 == 1) begin
        part[n/2] = part[n-1];
      end
    end
    return part[0];
  endfunction

endpackage

FILE: hdl/altbit_evt_if.sv
interface altbit_evt_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic               seq_bit;
  logic               ack_bit;
  logic signed [15:0] in_checksum;
  logic [63:0]        payload_lo;
  logic [63:0]        payload_mid;
  logic [31:0]        payload_hi;

  modport source (output valid, command, seq_bit, ack_bit, in_checksum,
                  payload_lo, payload_mid, payload_hi, input ready);
  modport sink (input valid, command, seq_bit, ack_bit, in_checksum,
                payload_lo, payload_mid, payload_hi, output ready);
endinterface

FILE: hdl/altbit_res_if.sv
interface altbit_res_if;
  logic               valid;
  logic               ready;
  logic               send_valid;
  logic               out_seq;
  logic               out_ack;
  logic signed [12:0] out_checksum;
  logic [63:0]        out_payload_lo;
  logic [63:0]        out_payload_mid;
  logic [31:0]        out_payload_hi;
  logic               start_timer;
  logic               stop_timer;
  logic [15:0]        timer_load;
  logic [2:0]         status;

  modport source (output valid, send_valid, out_seq, out_ack, out_checksum,
                  out_payload_lo, out_payload_mid, out_payload_hi, start_timer,
                  stop_timer, timer_load, status, input ready);
  modport sink (input valid, send_valid, out_seq, out_ack, out_checksum,
                out_payload_lo, out_payload_mid, out_payload_hi, start_timer,
                stop_timer, timer_load, status, output ready);
endinterface

FILE: hdl/alternating_bit_sender_unit.sv
// an accepted transaction goes into the input register and then into the result
//   register, from which the result channel takes it; one transaction per cycle
//   while the result channel is ready; the checksum adder tree sits between
//   the input register and the result register, state updates in the same cycle
// reset (rst_ni low, async): idle, current bit 0, timeout 15, both stages empty;
//   the stored packet copy is not reset and is only read after a message wrote it
module alternating_bit_sender_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i,
  altbit_evt_if.sink   evt_i,
  altbit_res_if.source res_o
);

  // configuration register
  logic [altbit_pkg::TimerWidth-1:0] timeout_q;

  // input stage
  logic        s1_valid_q;
  logic [1:0]  s1_cmd_q;
  logic        s1_seq_q;
  logic        s1_ack_q;
  logic signed [15:0] s1_csum_q;
  logic [altbit_pkg::PayloadBits-1:0] s1_data_q;
  logic        s1_adv;

  // protocol state
  logic        waiting_q, waiting_d;
  logic        cur_bit_q, cur_bit_d;
  logic        sent_bit_q;
  logic [altbit_pkg::PayloadBits-1:0] saved_data_q;
  logic signed [altbit_pkg::CsumWidth-1:0] saved_csum_q;
  logic        save_en;

  // result stage
  logic        out_valid_q;
  logic        send_q, start_q, stop_q;
  logic        bit_q;
  logic signed [altbit_pkg::CsumWidth-1:0] csum_q;
  logic [altbit_pkg::PayloadBits-1:0] data_q;
  logic [altbit_pkg::TimerWidth-1:0] load_q;
  logic [2:0]  status_q;

  // combinational results
  logic signed [altbit_pkg::CsumWidth-1:0] sum_bytes, msg_sum, pkt_sum;
  logic        send_d, start_d, stop_d, bit_d;
  logic signed [altbit_pkg::CsumWidth-1:0] csum_d;
  logic [altbit_pkg::PayloadBits-1:0] data_d;
  altbit_pkg::status_e status_d;

  assign s1_adv      = s1_valid_q && (!out_valid_q || res_o.ready);
  assign evt_i.ready = !s1_valid_q || s1_adv;

  // configuration write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= altbit_pkg::TimeoutReset;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (evt_i.ready) begin
      s1_valid_q <= evt_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_i.valid && evt_i.ready) begin
      s1_cmd_q  <= evt_i.command;
      s1_seq_q  <= evt_i.seq_bit;
      s1_ack_q  <= evt_i.ack_bit;
      s1_csum_q <= evt_i.in_checksum;
      s1_data_q <= {evt_i.payload_hi, evt_i.payload_mid, evt_i.payload_lo};
    end
  end

  // checksums for an outgoing message and an arriving packet
  assign sum_bytes = altbit_pkg::byte_sum(s1_data_q);
  assign msg_sum   = sum_bytes + altbit_pkg::CsumWidth'({cur_bit_q, cur_bit_q} == 2'b11 ? 2 :
                                                        (cur_bit_q ? 1 : 0));
  assign pkt_sum   = sum_bytes + altbit_pkg::CsumWidth'(s1_seq_q) +
                     altbit_pkg::CsumWidth'(s1_ack_q);

  // event decode
  always_comb begin
    waiting_d = waiting_q;
    cur_bit_d = cur_bit_q;
    save_en   = 1'b0;
    send_d    = 1'b0;
    start_d   = 1'b0;
    stop_d    = 1'b0;
    status_d  = altbit_pkg::StTimerIgn;
    unique case (altbit_pkg::cmd_e'(s1_cmd_q))
      altbit_pkg::CmdMessage: begin
        if (waiting_q) begin
          status_d = altbit_pkg::StBusy;
        end else begin
          save_en   = 1'b1;
          waiting_d = 1'b1;
          send_d    = 1'b1;
          start_d   = 1'b1;
          status_d  = altbit_pkg::StSent;
        end
      end
      altbit_pkg::CmdPacket: begin
        if (!waiting_q) begin
          status_d = altbit_pkg::StWrongAck;
        end else if (16'(pkt_sum) != s1_csum_q) begin
          status_d = altbit_pkg::StCorruptAck;
        end else if (s1_ack_q != sent_bit_q) begin
          status_d = altbit_pkg::StWrongAck;
        end else begin
          cur_bit_d = !cur_bit_q;
          waiting_d = 1'b0;
          stop_d    = 1'b1;
          status_d  = altbit_pkg::StAckOk;
        end
      end
      altbit_pkg::CmdTimer: begin
        if (waiting_q) begin
          send_d   = 1'b1;
          start_d  = 1'b1;
          status_d = altbit_pkg::StResent;
        end
      end
      default: begin
        status_d = altbit_pkg::StTimerIgn;
      end
    endcase
  end

  // packet contents: a fresh message bypasses the stored copy
  assign bit_d  = save_en ? cur_bit_q : sent_bit_q;
  assign csum_d = save_en ? msg_sum : saved_csum_q;
  assign data_d = save_en ? s1_data_q : saved_data_q;

  // protocol state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waiting_q  <= 1'b0;
      cur_bit_q  <= 1'b0;
      sent_bit_q <= 1'b0;
    end else if (s1_adv) begin
      waiting_q <= waiting_d;
      cur_bit_q <= cur_bit_d;
      if (save_en) begin
        sent_bit_q <= cur_bit_q;
      end
    end
  end

  // stored copy for retransmission
  always_ff @(posedge clk_i) begin
    if (s1_adv && save_en) begin
      saved_data_q <= s1_data_q;
      saved_csum_q <= msg_sum;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      send_q   <= send_d;
      start_q  <= start_d;
      stop_q   <= stop_d;
      bit_q    <= send_d & bit_d;
      csum_q   <= send_d ? csum_d : '0;
      data_q   <= send_d ? data_d : '0;
      load_q   <= start_d ? timeout_q : '0;
      status_q <= status_d;
    end
  end

  // result channel
  assign res_o.valid           = out_valid_q;
  assign res_o.send_valid      = send_q;
  assign res_o.out_seq         = bit_q;
  assign res_o.out_ack         = bit_q;
  assign res_o.out_checksum    = csum_q;
  assign res_o.out_payload_lo  = data_q[63:0];
  assign res_o.out_payload_mid = data_q[127:64];
  assign res_o.out_payload_hi  = data_q[159:128];
  assign res_o.start_timer     = start_q;
  assign res_o.stop_timer      = stop_q;
  assign res_o.timer_load      = load_q;
  assign res_o.status          = status_q;

endmodule

FILE: tb/alternating_bit_sender_unit_tb.sv
`timescale 1ns / 1ps

module alternating_bit_sender_unit_tb;

  localparam logic [1:0] CmdReserved = 2'd3;
  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 400;
  localparam int MaxReports = 10;

  // one event transaction as driven on the input channel
  typedef struct packed {
    logic [1:0]         cmd;
    logic               seq;
    logic               ack;
    logic signed [15:0] csum;
    logic [159:0]       payload;
  } evt_t;

  // one reply transaction as seen on the result channel
  typedef struct packed {
    logic        send_valid;
    logic        seq;
    logic        ack;
    logic [12:0] csum;
    logic [63:0] lo;
    logic [63:0] mid;
    logic [31:0] hi;
    logic        start_timer;
    logic        stop_timer;
    logic [15:0] timer_load;
    logic [2:0]  status;
  } reply_t;

  // sender state tracker and reply checker
  class altbit_scoreboard;
    logic         waiting;
    logic         cur_bit;
    logic         sent_bit;
    logic [159:0] saved_payload;
    logic [12:0]  saved_csum;
    logic [15:0]  timeout;
    reply_t       reply_q[$];
    int           fail_count;

    function new();
      waiting       = 1'b0;
      cur_bit       = 1'b0;
      sent_bit      = 1'b0;
      saved_payload = '0;
      saved_csum    = '0;
      timeout       = altbit_pkg::TimeoutReset;
      fail_count    = 0;
    endfunction

    // seq + ack + all payload bytes, each byte signed
    static function int packet_sum(logic seq, logic ack, logic [159:0] p);
      int  s;
      byte b;
      s = int'(seq) + int'(ack);
      for (int i = 0; i < altbit_pkg::PayloadBytes; i++) begin
        b = p[8*i +: 8];
        s = s + b;
      end
      return s;
    endfunction

    // accepted event: advance state and queue the predicted reply
    function void note_event(evt_t e);
      reply_t r;
      int     s;
      int     got;
      bit     do_send;
      bit     do_start;
      r        = '0;
      r.status = altbit_pkg::StTimerIgn;
      do_send  = 1'b0;
      do_start = 1'b0;
      case (e.cmd)
        altbit_pkg::CmdMessage: begin
          if (waiting) begin
            r.status = altbit_pkg::StBusy;
          end else begin
            s             = packet_sum(cur_bit, cur_bit, e.payload);
            saved_csum    = s[12:0];
            saved_payload = e.payload;
            sent_bit      = cur_bit;
            waiting       = 1'b1;
            do_send       = 1'b1;
            do_start      = 1'b1;
            r.status      = altbit_pkg::StSent;
          end
        end
        altbit_pkg::CmdPacket: begin
          if (!waiting) begin
            r.status = altbit_pkg::StWrongAck;
          end else begin
            got = $signed(e.csum);
            if (got != packet_sum(e.seq, e.ack, e.payload)) begin
              r.status = altbit_pkg::StCorruptAck;
            end else if (e.ack != sent_bit) begin
              r.status = altbit_pkg::StWrongAck;
            end else begin
              cur_bit      = ~cur_bit;
              waiting      = 1'b0;
              r.stop_timer = 1'b1;
              r.status     = altbit_pkg::StAckOk;
            end
          end
        end
        altbit_pkg::CmdTimer: begin
          if (waiting) begin
            do_send  = 1'b1;
            do_start = 1'b1;
            r.status = altbit_pkg::StResent;
          end
        end
        default: ;
      endcase
      if (do_send) begin
        r.send_valid = 1'b1;
        r.seq        = sent_bit;
        r.ack        = sent_bit;
        r.csum       = saved_csum;
        r.lo         = saved_payload[63:0];
        r.mid        = saved_payload[127:64];
        r.hi         = saved_payload[159:128];
      end
      if (do_start) begin
        r.start_timer = 1'b1;
        r.timer_load  = timeout;
      end
      reply_q.push_back(r);
    endfunction

    // accepted reply: compare against the oldest prediction
    function void check_reply(reply_t got);
      reply_t want;
      string  bad;
      if (reply_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxReports)
          $display("unexpected reply at %0t: %h", $realtime, got);
        return;
      end
      want = reply_q.pop_front();
      bad  = "";
      if (got.send_valid !== want.send_valid) bad = {bad, " send_valid"};
      if (got.seq !== want.seq) bad = {bad, " out_seq"};
      if (got.ack !== want.ack) bad = {bad, " out_ack"};
      if (got.csum !== want.csum) bad = {bad, " out_checksum"};
      if (got.lo !== want.lo) bad = {bad, " out_payload_lo"};
      if (got.mid !== want.mid) bad = {bad, " out_payload_mid"};
      if (got.hi !== want.hi) bad = {bad, " out_payload_hi"};
      if (got.start_timer !== want.start_timer) bad = {bad, " start_timer"};
      if (got.stop_timer !== want.stop_timer) bad = {bad, " stop_timer"};
      if (got.timer_load !== want.timer_load) bad = {bad, " timer_load"};
      if (got.status !== want.status) bad = {bad, " status"};
      if (bad != "") begin
        fail_count++;
        if (fail_count <= MaxReports) begin
          $display("reply mismatch at %0t in%s", $realtime, bad);
          $display("  exp %h", want);
          $display("  got %h", got);
        end
      end
    endfunction

    // predictions still open at the end are failures
    function void close_out();
      if (reply_q.size() != 0) begin
        fail_count++;
        $display("%0d replies never arrived", reply_q.size());
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  int          rcv_idle_pct;
  bit          hold_req;
  int          cycle_cnt;

  altbit_scoreboard sb;

  altbit_evt_if evt_if ();
  altbit_res_if res_if ();

  alternating_bit_sender_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .evt_i       (evt_if.sink),
    .res_o       (res_if.source)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles", cycle_cnt);
    $display("Verification failed");
    $finish;
  end

  // result side ready, with random stalls and the long hold-off
  initial begin
    int hold_left;
    hold_left    = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // reply monitor
  initial begin
    reply_t got;
    forever begin
      @(posedge clk_i);
      if (rst_ni === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
        got.send_valid  = res_if.send_valid;
        got.seq         = res_if.out_seq;
        got.ack         = res_if.out_ack;
        got.csum        = res_if.out_checksum;
        got.lo          = res_if.out_payload_lo;
        got.mid         = res_if.out_payload_mid;
        got.hi          = res_if.out_payload_hi;
        got.start_timer = res_if.start_timer;
        got.stop_timer  = res_if.stop_timer;
        got.timer_load  = res_if.timer_load;
        got.status      = res_if.status;
        sb.check_reply(got);
      end
    end
  end

  // drive one event and wait for its transaction; returns just after a falling edge
  task automatic send_evt(input evt_t e);
    evt_if.valid       <= 1'b1;
    evt_if.command     <= e.cmd;
    evt_if.seq_bit     <= e.seq;
    evt_if.ack_bit     <= e.ack;
    evt_if.in_checksum <= e.csum;
    evt_if.payload_lo  <= e.payload[63:0];
    evt_if.payload_mid <= e.payload[127:64];
    evt_if.payload_hi  <= e.payload[159:128];
    do @(posedge clk_i); while (evt_if.ready !== 1'b1);
    sb.note_event(e);
    @(negedge clk_i);
  endtask

  task automatic idle_cycle();
    evt_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic dir_evt(input logic [1:0] cmd, input logic seq, input logic ack,
                         input logic signed [15:0] csum, input logic [159:0] p);
    evt_t e;
    e.cmd     = cmd;
    e.seq     = seq;
    e.ack     = ack;
    e.csum    = csum;
    e.payload = p;
    send_evt(e);
  endtask

  // network packet carrying its correct checksum
  task automatic ack_evt(input logic seq, input logic ack, input logic [159:0] p);
    dir_evt(altbit_pkg::CmdPacket, seq, ack,
            16'(altbit_scoreboard::packet_sum(seq, ack, p)), p);
  endtask

  // mostly random bytes, sometimes built from extreme byte values
  function automatic logic [159:0] rand_payload();
    logic [159:0] p;
    if ($urandom_range(9) < 7) begin
      p = {$urandom, $urandom, $urandom, $urandom, $urandom};
    end else begin
      for (int i = 0; i < altbit_pkg::PayloadBytes; i++) begin
        case ($urandom_range(4))
          0:       p[8*i +: 8] = 8'h00;
          1:       p[8*i +: 8] = 8'h7F;
          2:       p[8*i +: 8] = 8'h80;
          3:       p[8*i +: 8] = 8'hFF;
          default: p[8*i +: 8] = 8'($urandom);
        endcase
      end
    end
    return p;
  endfunction

  // wait for every predicted reply, then let the pipeline settle
  task automatic drain();
    evt_if.valid <= 1'b0;
    while (sb.reply_q.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_timeout(input logic [15:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we     <= 1'b0;
    sb.timeout = v;
  endtask

  // one random event, shaped by the current protocol state
  task automatic random_event(output bit counted);
    evt_t e;
    int   pick;
    int   good;
    e.payload = rand_payload();
    e.seq     = 1'($urandom);
    e.ack     = 1'($urandom);
    e.csum    = 16'($urandom);
    pick      = $urandom_range(99);
    if (!sb.waiting) begin
      // idle: mostly new messages, some ignored noise
      if (pick < 80) e.cmd = altbit_pkg::CmdMessage;
      else if (pick < 87) e.cmd = altbit_pkg::CmdPacket;
      else if (pick < 94) e.cmd = altbit_pkg::CmdTimer;
      else e.cmd = CmdReserved;
      counted = (e.cmd == altbit_pkg::CmdMessage);
    end else begin
      counted = 1'b1;
      if (pick < 45) begin
        e.cmd  = altbit_pkg::CmdPacket;
        e.ack  = sb.sent_bit;
        e.csum = 16'(altbit_scoreboard::packet_sum(e.seq, e.ack, e.payload));
      end else if (pick < 65) begin
        e.cmd = altbit_pkg::CmdTimer;
      end else if (pick < 75) begin
        // corrupt checksum, near the right value or anywhere
        e.cmd = altbit_pkg::CmdPacket;
        good  = altbit_scoreboard::packet_sum(e.seq, e.ack, e.payload);
        if ($urandom_range(1)) e.csum = 16'(good + int'($urandom_range(40)) - 20);
      end else if (pick < 85) begin
        e.cmd  = altbit_pkg::CmdPacket;
        e.ack  = ~sb.sent_bit;
        e.csum = 16'(altbit_scoreboard::packet_sum(e.seq, e.ack, e.payload));
      end else if (pick < 95) begin
        e.cmd = altbit_pkg::CmdMessage;
      end else begin
        e.cmd   = CmdReserved;
        counted = 1'b0;
      end
    end
    send_evt(e);
  endtask

  task automatic run_phase(input int n_items, input int snd_pct, input int rcv_pct,
                           input bit pressure);
    int done;
    bit counted;
    bit held;
    bit paused;
    done         = 0;
    held         = 1'b0;
    paused       = 1'b0;
    rcv_idle_pct = rcv_pct;
    while (done < n_items) begin
      while ($urandom_range(99) < snd_pct) idle_cycle();
      // long receiver hold-off while events keep coming
      if (pressure && !held && done >= 100) begin
        hold_req = 1'b1;
        held     = 1'b1;
      end
      // sender pause until all replies are in
      if (pressure && !paused && done >= 250) begin
        paused = 1'b1;
        drain();
      end
      random_event(counted);
      if (counted) done++;
    end
    idle_cycle();
  endtask

  // main sequence
  initial begin
    rst_ni             = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    rcv_idle_pct       = 0;
    hold_req           = 1'b0;
    evt_if.valid       = 1'b0;
    evt_if.command     = altbit_pkg::CmdMessage;
    evt_if.seq_bit     = 1'b0;
    evt_if.ack_bit     = 1'b0;
    evt_if.in_checksum = '0;
    evt_if.payload_lo  = '0;
    evt_if.payload_mid = '0;
    evt_if.payload_hi  = '0;
    sb = new();
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: idle noise, all statuses, checksum extremes, reset timeout value
    dir_evt(altbit_pkg::CmdTimer, 1'b0, 1'b0, '0, '0);
    ack_evt(1'b0, 1'b0, '0);
    dir_evt(CmdReserved, 1'b1, 1'b1, 16'sh7FFF, '1);
    dir_evt(altbit_pkg::CmdMessage, 1'b0, 1'b0, '0, {20{8'h80}});
    dir_evt(altbit_pkg::CmdMessage, 1'b1, 1'b1, -16'sd1, '1);
    dir_evt(CmdReserved, 1'b0, 1'b0, '0, rand_payload());
    dir_evt(altbit_pkg::CmdTimer, 1'b0, 1'b0, '0, rand_payload());
    dir_evt(altbit_pkg::CmdPacket, 1'b0, 1'b0, 16'sh7FFF, '0);
    ack_evt(1'b1, 1'b1, {20{8'h80}});
    dir_evt(altbit_pkg::CmdPacket, 1'b1, 1'b0, 16'sh8000, {20{8'h80}});
    ack_evt(1'b1, 1'b0, rand_payload());
    dir_evt(altbit_pkg::CmdMessage, 1'b0, 1'b0, '0, {20{8'h7F}});
    ack_evt(1'b0, 1'b0, rand_payload());
    ack_evt(1'b0, 1'b1, {20{8'h7F}});
    dir_evt(altbit_pkg::CmdMessage, 1'b0, 1'b0, '0, '0);
    dir_evt(altbit_pkg::CmdTimer, 1'b1, 1'b1, '0, '1);
    ack_evt(1'b1, 1'b0, '1);
    dir_evt(altbit_pkg::CmdMessage, 1'b0, 1'b0, '0, '1);
    dir_evt(altbit_pkg::CmdTimer, 1'b0, 1'b0, '0, '0);
    ack_evt(1'b1, 1'b1, {20{8'h7F}});
    dir_evt(altbit_pkg::CmdMessage, 1'b1, 1'b0, '0, rand_payload());
    ack_evt(1'b0, 1'b0, rand_payload());
    idle_cycle();

    // random phases across timeout settings and idling patterns
    set_timeout(16'hFFFF);
    run_phase(410, 10, 73, 1'b0);
    set_timeout(16'd1);
    run_phase(410, 73, 10, 1'b0);
    set_timeout(16'($urandom_range(65535, 1)));
    run_phase(410, 0, 0, 1'b1);
    set_timeout(16'd0);
    run_phase(50, 0, 0, 1'b0);

    drain();
    repeat (8) @(posedge clk_i);
    sb.close_out();
    if (sb.fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: alternating_bit_sender_unit.f
hdl/altbit_pkg.sv
hdl/altbit_evt_if.sv
hdl/altbit_res_if.sv
hdl/alternating_bit_sender_unit.sv
tb/alternating_bit_sender_unit_tb.sv
